FILE: src/clbc_pkg.sv
package clbc_pkg;

  // table size and derived widths
  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IW      = $clog2(ENTRIES);
  localparam int unsigned CW      = $clog2(ENTRIES + 1);
  localparam int unsigned EW      = 32 + 16 + IW;
  localparam int unsigned QDEPTH  = 2;

  // action codes on the input word
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_INVAL  = 2'd2;

  // work classes decided by the front end
  typedef enum logic [1:0] {
    KIND_LOOKUP,
    KIND_INSERT,
    KIND_INVAL,
    KIND_NOP
  } kind_e;

  // classified word handed from front to back
  typedef struct packed {
    kind_e        kind;
    logic [31:0]  addr;
    logic [15:0]  instrs;
    logic [32:0]  rend;
  } item_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [31:0]   start;
    logic [15:0]   len;
    logic [IW-1:0] age;
  } entry_t;

  // low six bits of a slot number
  function automatic logic [5:0] to_slot(input logic [IW-1:0] s);
    logic [IW+5:0] t;
    t = {6'd0, s};
    return t[5:0];
  endfunction

  // low seven bits of a count
  function automatic logic [6:0] to_cnt(input logic [CW-1:0] c);
    logic [CW+6:0] t;
    t = {7'd0, c};
    return t[6:0];
  endfunction

endpackage

FILE: src/clbc_ram.sv
module clbc_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/clbc_front.sv
module clbc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [31:0]       addr_i,
  input  logic [15:0]       block_instrs_i,
  input  logic [31:0]       range_bytes_i,
  output logic              q_valid_o,
  output clbc_pkg::item_t   q_item_o,
  input  logic              q_pop_i
);
  import clbc_pkg::*;

  item_t       item;
  item_t       mem_q [QDEPTH];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  // classify the incoming word and form the range end in 33 bits
  always_comb begin
    item.addr   = addr_i;
    item.instrs = block_instrs_i;
    item.rend   = {1'b0, addr_i} + {1'b0, range_bytes_i};
    case (action_i)
      ACT_LOOKUP: item.kind = KIND_LOOKUP;
      ACT_INSERT: item.kind = KIND_INSERT;
      ACT_INVAL:  item.kind = (range_bytes_i == 32'd0) ? KIND_NOP : KIND_INVAL;
      default:    item.kind = KIND_NOP;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];

  // queue pointers
  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= item;
    end
  end

endmodule

FILE: src/clbc_back.sv
module clbc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  clbc_pkg::item_t   q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              hit_o,
  output logic [5:0]        slot_o,
  output logic              evicted_o,
  output logic [5:0]        evicted_slot_o,
  output logic [6:0]        removed_count_o,
  output logic [6:0]        occupancy_o,
  output logic [31:0]       eviction_total_o,
  output logic [31:0]       removal_total_o
);
  import clbc_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_FIND    = 4'd1;
  localparam logic [3:0] ST_PROMOTE = 4'd2;
  localparam logic [3:0] ST_DEC     = 4'd3;
  localparam logic [3:0] ST_OLD     = 4'd4;
  localparam logic [3:0] ST_FREE    = 4'd5;
  localparam logic [3:0] ST_INC     = 4'd6;
  localparam logic [3:0] ST_PUT     = 4'd7;
  localparam logic [3:0] ST_MARK    = 4'd8;
  localparam logic [3:0] ST_CUM     = 4'd9;
  localparam logic [3:0] ST_RENUM   = 4'd10;
  localparam logic [3:0] ST_DONE    = 4'd11;

  logic [3:0]          state_q, state_d;
  kind_e               kind_q, kind_d;
  logic [31:0]         key_q, key_d;
  logic [15:0]         len_q, len_d;
  logic [32:0]         rend_q, rend_d;

  // scan engine
  logic                iss_q, iss_d;
  logic [CW-1:0]       ridx_q, ridx_d, lim_q, lim_d;
  logic                s1_vld_q, s1_vld_d;
  logic [IW-1:0]       s1_idx_q, s1_idx_d;
  logic                s2_vld_q, s2_vld_d;
  logic [IW-1:0]       s2_idx_q, s2_idx_d;
  entry_t              s2_ent_q, s2_ent_d;
  logic                go;
  logic [CW-1:0]       go_lim;
  logic                pass_done;

  // table state
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [CW-1:0]       count_q, count_d;
  logic [31:0]         evtot_q, evtot_d, rmtot_q, rmtot_d;

  // per-word working registers
  logic                fnd_q, fnd_d;
  logic [IW-1:0]       fslot_q, fslot_d, fage_q, fage_d;
  logic                hit_q, hit_d, evd_q, evd_d;
  logic [IW-1:0]       rslot_q, rslot_d, evslot_q, evslot_d;
  logic [CW-1:0]       rmcnt_q, rmcnt_d, run_q, run_d;

  // output word
  logic                ovld_q, ovld_d;
  logic                ohit_q, ohit_d, oev_q, oev_d;
  logic [5:0]          oslot_q, oslot_d, oevslot_q, oevslot_d;
  logic [6:0]          orm_q, orm_d, oocc_q, oocc_d;
  logic [31:0]         oevtot_q, oevtot_d, ormtot_q, ormtot_d;

  // memories
  logic                ent_we;
  logic [IW-1:0]       ent_waddr;
  entry_t              ent_wdata, ent_rdata;
  logic [EW-1:0]       ent_rraw;
  logic                rm_we, rm_wdata, rm_rdata;
  logic                cum_we;
  logic [CW-1:0]       cum_rdata;

  logic                live;
  logic [32:0]         bend;
  logic                ovl;
  logic                full;

  clbc_ram #(.W(EW), .D(ENTRIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ridx_q[IW-1:0]),
    .rdata_o (ent_rraw)
  );

  // removal flags per recency rank
  clbc_ram #(.W(1), .D(ENTRIES)) u_rm_ram (
    .clk_i   (clk_i),
    .we_i    (rm_we),
    .waddr_i (ent_rdata.age),
    .wdata_i (rm_wdata),
    .raddr_i (ridx_q[IW-1:0]),
    .rdata_o (rm_rdata)
  );

  // removed ranks below each rank
  clbc_ram #(.W(CW), .D(ENTRIES)) u_cum_ram (
    .clk_i   (clk_i),
    .we_i    (cum_we),
    .waddr_i (s1_idx_q),
    .wdata_i (run_q),
    .raddr_i (ent_rdata.age),
    .rdata_o (cum_rdata)
  );

  assign ent_rdata = ent_rraw;
  assign live      = valid_q[s1_idx_q];
  assign pass_done = !iss_q && !s1_vld_q && !s2_vld_q;
  assign full      = (count_q == CW'(ENTRIES));
  assign bend      = {1'b0, ent_rdata.start} + {15'd0, ent_rdata.len, 2'b00};
  assign ovl       = (ent_rdata.len != 16'd0) && ({1'b0, ent_rdata.start} < rend_q)
                     && (bend > {1'b0, key_q});

  // sequencer
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    key_d     = key_q;
    len_d     = len_q;
    rend_d    = rend_q;
    valid_d   = valid_q;
    count_d   = count_q;
    evtot_d   = evtot_q;
    rmtot_d   = rmtot_q;
    fnd_d     = fnd_q;
    fslot_d   = fslot_q;
    fage_d    = fage_q;
    hit_d     = hit_q;
    evd_d     = evd_q;
    rslot_d   = rslot_q;
    evslot_d  = evslot_q;
    rmcnt_d   = rmcnt_q;
    run_d     = run_q;
    ovld_d    = ovld_q && out_stall_i;
    ohit_d    = ohit_q;
    oev_d     = oev_q;
    oslot_d   = oslot_q;
    oevslot_d = oevslot_q;
    orm_d     = orm_q;
    oocc_d    = oocc_q;
    oevtot_d  = oevtot_q;
    ormtot_d  = ormtot_q;
    q_pop_o   = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = s1_idx_q;
    ent_wdata = ent_rdata;
    rm_we     = 1'b0;
    rm_wdata  = 1'b0;
    cum_we    = 1'b0;
    go        = 1'b0;
    go_lim    = CW'(ENTRIES);

    // issue one read a cycle while a pass runs
    iss_d    = iss_q;
    ridx_d   = ridx_q;
    lim_d    = lim_q;
    if (iss_q) begin
      ridx_d = ridx_q + CW'(1);
      if (ridx_q + CW'(1) == lim_q) begin
        iss_d = 1'b0;
      end
    end
    s1_vld_d = iss_q;
    s1_idx_d = ridx_q[IW-1:0];
    s2_vld_d = 1'b0;
    s2_idx_d = s1_idx_q;
    s2_ent_d = ent_rdata;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          kind_d   = q_item_i.kind;
          key_d    = q_item_i.addr;
          len_d    = q_item_i.instrs;
          rend_d   = q_item_i.rend;
          fnd_d    = 1'b0;
          hit_d    = 1'b0;
          evd_d    = 1'b0;
          rslot_d  = '0;
          evslot_d = '0;
          rmcnt_d  = '0;
          case (q_item_i.kind)
            KIND_LOOKUP, KIND_INSERT: begin
              state_d = ST_FIND;
              go      = 1'b1;
            end
            KIND_INVAL: begin
              state_d = ST_MARK;
              go      = 1'b1;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      // first valid entry with a matching start
      ST_FIND: begin
        if (s1_vld_q && live && !fnd_q && ent_rdata.start == key_q) begin
          fnd_d   = 1'b1;
          fslot_d = s1_idx_q;
          fage_d  = ent_rdata.age;
        end
        if (pass_done) begin
          go = 1'b1;
          if (kind_q == KIND_LOOKUP) begin
            if (fnd_q) begin
              hit_d   = 1'b1;
              rslot_d = fslot_q;
              state_d = ST_PROMOTE;
            end else begin
              go      = 1'b0;
              state_d = ST_DONE;
            end
          end else if (fnd_q) begin
            // repair: drop the old copy quietly
            valid_d[fslot_q] = 1'b0;
            count_d          = count_q - CW'(1);
            state_d          = ST_DEC;
          end else if (full) begin
            fnd_d   = 1'b0;
            state_d = ST_OLD;
          end else begin
            fnd_d   = 1'b0;
            state_d = ST_FREE;
          end
        end
      end

      // hit entry becomes most recent
      ST_PROMOTE: begin
        if (s1_vld_q && live) begin
          ent_we = 1'b1;
          if (s1_idx_q == fslot_q) begin
            ent_wdata.age = '0;
          end else if (ent_rdata.age < fage_q) begin
            ent_wdata.age = ent_rdata.age + IW'(1);
          end
        end
        if (pass_done) begin
          state_d = ST_DONE;
        end
      end

      // close the rank gap left by a dropped entry
      ST_DEC: begin
        if (s1_vld_q && live && ent_rdata.age > fage_q) begin
          ent_we        = 1'b1;
          ent_wdata.age = ent_rdata.age - IW'(1);
        end
        if (pass_done) begin
          go    = 1'b1;
          fnd_d = 1'b0;
          if (!evd_q && full) begin
            state_d = ST_OLD;
          end else begin
            state_d = ST_FREE;
          end
        end
      end

      // least recent entry
      ST_OLD: begin
        if (s1_vld_q && live && !fnd_q && ent_rdata.age == IW'(ENTRIES - 1)) begin
          fnd_d   = 1'b1;
          fslot_d = s1_idx_q;
          fage_d  = ent_rdata.age;
        end
        if (pass_done) begin
          go = 1'b1;
          if (fnd_q) begin
            valid_d[fslot_q] = 1'b0;
            count_d          = count_q - CW'(1);
            evd_d            = 1'b1;
            evslot_d         = fslot_q;
            evtot_d          = evtot_q + 32'd1;
            rmtot_d          = rmtot_q + 32'd1;
            state_d          = ST_DEC;
          end else begin
            fnd_d   = 1'b0;
            state_d = ST_FREE;
          end
        end
      end

      // lowest free slot
      ST_FREE: begin
        if (s1_vld_q && !live && !fnd_q) begin
          fnd_d   = 1'b1;
          fslot_d = s1_idx_q;
        end
        if (pass_done) begin
          if (fnd_q) begin
            go      = 1'b1;
            state_d = ST_INC;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      // every live entry ages by one
      ST_INC: begin
        if (s1_vld_q && live) begin
          ent_we        = 1'b1;
          ent_wdata.age = ent_rdata.age + IW'(1);
        end
        if (pass_done) begin
          state_d = ST_PUT;
        end
      end

      // write the new block as most recent
      ST_PUT: begin
        ent_we           = 1'b1;
        ent_waddr        = fslot_q;
        ent_wdata.start  = key_q;
        ent_wdata.len    = len_q;
        ent_wdata.age    = '0;
        valid_d[fslot_q] = 1'b1;
        count_d          = count_q + CW'(1);
        rslot_d          = fslot_q;
        state_d          = ST_DONE;
      end

      // clear overlapping entries, flag their ranks
      ST_MARK: begin
        if (s1_vld_q && live) begin
          rm_we    = 1'b1;
          rm_wdata = ovl;
          if (ovl) begin
            valid_d[s1_idx_q] = 1'b0;
            rmcnt_d           = rmcnt_q + CW'(1);
          end
        end
        if (pass_done) begin
          if (rmcnt_q == '0) begin
            state_d = ST_DONE;
          end else begin
            go      = 1'b1;
            go_lim  = count_q;
            run_d   = '0;
            state_d = ST_CUM;
          end
        end
      end

      // running count of removed ranks
      ST_CUM: begin
        if (s1_vld_q) begin
          cum_we = 1'b1;
          run_d  = run_q + CW'(rm_rdata);
        end
        if (pass_done) begin
          go      = 1'b1;
          state_d = ST_RENUM;
        end
      end

      // survivors drop by the removed ranks below them
      ST_RENUM: begin
        s2_vld_d = s1_vld_q && live;
        if (s2_vld_q) begin
          ent_we        = 1'b1;
          ent_waddr     = s2_idx_q;
          ent_wdata     = s2_ent_q;
          ent_wdata.age = s2_ent_q.age - cum_rdata[IW-1:0];
        end
        if (pass_done) begin
          count_d = count_q - rmcnt_q;
          rmtot_d = rmtot_q + 32'(rmcnt_q);
          state_d = ST_DONE;
        end
      end

      // hand the result word to the output register
      ST_DONE: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d    = 1'b1;
          ohit_d    = hit_q;
          oslot_d   = to_slot(rslot_q);
          oev_d     = evd_q;
          oevslot_d = to_slot(evslot_q);
          orm_d     = to_cnt(rmcnt_q);
          oocc_d    = to_cnt(count_q);
          oevtot_d  = evtot_q;
          ormtot_d  = rmtot_q;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (go) begin
      iss_d  = 1'b1;
      ridx_d = '0;
      lim_d  = go_lim;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      iss_q    <= 1'b0;
      ridx_q   <= '0;
      lim_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      valid_q  <= '0;
      count_q  <= '0;
      evtot_q  <= '0;
      rmtot_q  <= '0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      ridx_q   <= ridx_d;
      lim_q    <= lim_d;
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
      valid_q  <= valid_d;
      count_q  <= count_d;
      evtot_q  <= evtot_d;
      rmtot_q  <= rmtot_d;
      ovld_q   <= ovld_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    key_q     <= key_d;
    len_q     <= len_d;
    rend_q    <= rend_d;
    s1_idx_q  <= s1_idx_d;
    s2_idx_q  <= s2_idx_d;
    s2_ent_q  <= s2_ent_d;
    fnd_q     <= fnd_d;
    fslot_q   <= fslot_d;
    fage_q    <= fage_d;
    hit_q     <= hit_d;
    evd_q     <= evd_d;
    rslot_q   <= rslot_d;
    evslot_q  <= evslot_d;
    rmcnt_q   <= rmcnt_d;
    run_q     <= run_d;
    ohit_q    <= ohit_d;
    oev_q     <= oev_d;
    oslot_q   <= oslot_d;
    oevslot_q <= oevslot_d;
    orm_q     <= orm_d;
    oocc_q    <= oocc_d;
    oevtot_q  <= oevtot_d;
    ormtot_q  <= ormtot_d;
  end

  assign out_valid_o      = ovld_q;
  assign hit_o            = ohit_q;
  assign slot_o           = oslot_q;
  assign evicted_o        = oev_q;
  assign evicted_slot_o   = oevslot_q;
  assign removed_count_o  = orm_q;
  assign occupancy_o      = oocc_q;
  assign eviction_total_o = oevtot_q;
  assign removal_total_o  = ormtot_q;

endmodule

FILE: src/code_block_lru_cache.sv
// channel | handshake                | word
// --------+--------------------------+---------------------------------------------
// in      | in_valid_i, in_stall_o   | action_i addr_i block_instrs_i range_bytes_i
// out     | out_valid_o, out_stall_i | hit_o slot_o evicted_o evicted_slot_o
//         |                          | removed_count_o occupancy_o eviction_total_o
//         |                          | removal_total_o
//
// one word at a time is worked on; each pass walks the entry memory one entry a cycle
// lookup: one pass on a miss, two on a hit; insert: three to five passes;
// invalidate: none for an empty range, one pass, or three when something is removed
// a two-deep queue takes input words while the back end works; a stalled output
// holds the finished result and the back end waits; reset clears valid bits and totals
module code_block_lru_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] addr_i,
  input  logic [15:0] block_instrs_i,
  input  logic [31:0] range_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [5:0]  slot_o,
  output logic        evicted_o,
  output logic [5:0]  evicted_slot_o,
  output logic [6:0]  removed_count_o,
  output logic [6:0]  occupancy_o,
  output logic [31:0] eviction_total_o,
  output logic [31:0] removal_total_o
);
  import clbc_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // front: accept and classify
  clbc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .addr_i         (addr_i),
    .block_instrs_i (block_instrs_i),
    .range_bytes_i  (range_bytes_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  // back: table sequencer
  clbc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .slot_o           (slot_o),
    .evicted_o        (evicted_o),
    .evicted_slot_o   (evicted_slot_o),
    .removed_count_o  (removed_count_o),
    .occupancy_o      (occupancy_o),
    .eviction_total_o (eviction_total_o),
    .removal_total_o  (removal_total_o)
  );

endmodule
